// ===== rtl/line_density_accumulator_defines.svh =====
// Assertion macros used by the port-level checker file.
`ifndef LINE_DENSITY_ACCUMULATOR_DEFINES_SVH
`define LINE_DENSITY_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define LDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define LDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lda_pkg.sv =====
// Shared types and codes of the line density accumulator.
`timescale 1ns / 1ps
package lda_pkg;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REVERSED = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int CFG_BITS = 9;

    typedef struct packed {
        logic load;      // latch the accepted item
        logic mul;       // register level products
        logic setup;     // prepare line walk
        logic rd_cell;   // read the current line cell
        logic wr_cell;   // write back and step
        logic rd_read;   // read the cell of a read item
        logic cap_read;  // capture the read data
        logic clr_wr;    // clear one entry
        logic out_load;  // move result to the output register
    } lda_cmd_t;

    typedef struct packed {
        logic is_read;
        logic reversed;
        logic slice_ok;
        logic line_done;
        logic clr_last;
    } lda_stat_t;

endpackage

// ===== rtl/lda_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/lda_ctrl.sv =====
// Sequencer of the line density accumulator.
`timescale 1ns / 1ps
module lda_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  lda_pkg::lda_stat_t stat,
    output lda_pkg::lda_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_MUL   = 9'b000000100,
        ST_SETUP = 9'b000001000,
        ST_LRD   = 9'b000010000,
        ST_LWR   = 9'b000100000,
        ST_RDA   = 9'b001000000,
        ST_RDD   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.is_read)
                begin
                    state_next = ST_RDA;
                end
                else if (stat.reversed || !stat.slice_ok)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_LRD;
            end
            ST_LRD:
            begin
                if (stat.line_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.rd_cell = 1'b1;
                    state_next  = ST_LWR;
                end
            end
            ST_LWR:
            begin
                cmd.wr_cell = 1'b1;
                state_next  = ST_LRD;
            end
            ST_RDA:
            begin
                cmd.rd_read = 1'b1;
                state_next  = ST_RDD;
            end
            ST_RDD:
            begin
                cmd.cap_read = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register frees up
                if (!valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/lda_datapath.sv =====
// Datapath: configuration, row scaling, line walk and count store.
`timescale 1ns / 1ps
module lda_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int NUM_SLICES = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [lda_pkg::CFG_BITS-1:0] cfg_data,
    input  logic [79:0]                  s_tdata,
    input  logic                         s_tuser,
    output logic [47:0]                  m_tdata,
    output logic                         m_tuser,
    input  lda_pkg::lda_cmd_t            cmd,
    output lda_pkg::lda_stat_t           stat
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int SW = (NUM_SLICES > 1) ? $clog2(NUM_SLICES) : 1;
    localparam int AW = SW + YW + XW;
    localparam int EW = ((XW > YW) ? XW : YW) + 3;
    localparam int PW = 18 + YW + 1;

    logic [lda_pkg::CFG_BITS-1:0] width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lda_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                lda_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0]   wr32, hr32, w_m1_32, h_m1_32;
    logic [XW-1:0] w_m1;
    logic [YW-1:0] h_m1;

    assign wr32 = {23'd0, width_reg};
    assign hr32 = {23'd0, height_reg};
    assign w_m1_32 = (wr32 == 32'd0) ? 32'd0 :
                     (wr32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH - 1) : wr32 - 32'd1;
    assign h_m1_32 = (hr32 == 32'd0) ? 32'd0 :
                     (hr32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT - 1) : hr32 - 32'd1;
    assign w_m1 = w_m1_32[XW-1:0];
    assign h_m1 = h_m1_32[YW-1:0];

    logic [31:0] in_c0, in_c1, in_row;
    assign in_c0  = {16'd0, s_tdata[15:0]};
    assign in_c1  = {16'd0, s_tdata[31:16]};
    assign in_row = {24'd0, s_tdata[78:71]};

    // latched item
    logic               is_read_reg;
    logic [XW-1:0]      c0_reg, c1_reg;
    logic signed [17:0] lvl0_reg, lvl1_reg;
    logic [2:0]         slice_reg;
    logic [YW-1:0]      rrow_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_read_reg <= (s_tuser == lda_pkg::CMD_READ);
            c0_reg      <= (in_c0 > w_m1_32) ? w_m1 : in_c0[XW-1:0];
            c1_reg      <= (in_c1 > w_m1_32) ? w_m1 : in_c1[XW-1:0];
            lvl0_reg    <= $signed(s_tdata[49:32]);
            lvl1_reg    <= $signed(s_tdata[67:50]);
            slice_reg   <= s_tdata[70:68];
            rrow_reg    <= (in_row > h_m1_32) ? h_m1 : in_row[YW-1:0];
        end
    end

    logic [31:0]   slice32;
    logic [SW-1:0] slice_a;
    assign slice32 = {29'd0, slice_reg};
    assign slice_a = slice32[SW-1:0];

    // level scaling
    logic signed [YW:0]   hm1s;
    logic signed [PW-1:0] prod0_reg, prod1_reg;
    assign hm1s = $signed({1'b0, h_m1});

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod0_reg <= PW'(lvl0_reg * hm1s);
            prod1_reg <= PW'(lvl1_reg * hm1s);
        end
    end

    function automatic logic [YW-1:0] to_row(input logic signed [PW-1:0] p,
                                             input logic [YW-1:0] hm1);
        logic signed [PW-1:0] q;
        logic signed [PW-1:0] hx;
        begin
            q  = p >>> 16;
            hx = $signed({{(PW - YW){1'b0}}, hm1});
            if (p <= 0)
            begin
                to_row = '0;
            end
            else if (q > hx)
            begin
                to_row = hm1;
            end
            else
            begin
                to_row = q[YW-1:0];
            end
        end
    endfunction

    logic [YW-1:0] y0_c, y1_c, ady_c;
    assign y0_c  = to_row(prod0_reg, h_m1);
    assign y1_c  = to_row(prod1_reg, h_m1);
    assign ady_c = (y1_c > y0_c) ? (y1_c - y0_c) : (y0_c - y1_c);

    // line walk registers
    logic [XW-1:0]        x_reg, xe_reg;
    logic [YW-1:0]        y_reg, ye_reg;
    logic signed [EW-1:0] err_reg, dx_reg, dy_reg;
    logic                 sy_reg;
    logic [8:0]           pts_reg;
    logic signed [EW-1:0] dx_c, dy_c, e2;
    logic                 step_x, step_y;

    assign dx_c = $signed({{(EW - XW){1'b0}}, c1_reg})
                - $signed({{(EW - XW){1'b0}}, c0_reg});
    assign dy_c = -$signed({{(EW - YW){1'b0}}, ady_c});
    assign e2     = err_reg <<< 1;
    assign step_x = (e2 > dy_reg);
    assign step_y = (e2 < dx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            x_reg   <= c0_reg;
            xe_reg  <= c1_reg;
            y_reg   <= y0_c;
            ye_reg  <= y1_c;
            dx_reg  <= dx_c;
            dy_reg  <= dy_c;
            err_reg <= dx_c + dy_c;
            sy_reg  <= (y0_c < y1_c);
        end
        else if (cmd.wr_cell)
        begin
            err_reg <= err_reg + (step_x ? dy_reg : '0) + (step_y ? dx_reg : '0);
            if (step_x)
            begin
                x_reg <= x_reg + XW'(1);
            end
            if (step_y)
            begin
                y_reg <= sy_reg ? y_reg + YW'(1) : y_reg - YW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pts_reg <= '0;
        end
        else if (cmd.wr_cell)
        begin
            pts_reg <= pts_reg + 9'd1;
        end
    end

    // count store
    logic [AW-1:0]         clr_reg;
    logic [AW-1:0]         ram_addr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
    logic                  ram_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    always_comb
    begin
        priority if (cmd.clr_wr)
        begin
            ram_addr = clr_reg;
        end
        else if (cmd.rd_read)
        begin
            ram_addr = {slice_a, rrow_reg, c0_reg};
        end
        else
        begin
            ram_addr = {slice_a, y_reg, x_reg};
        end
    end

    assign ram_we    = cmd.clr_wr | cmd.wr_cell;
    assign ram_wdata = cmd.clr_wr ? '0 :
                       (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

    lda_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (2 ** AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  slice_ok;
    logic                  reversed;

    assign slice_ok = (slice32 < 32'(NUM_SLICES));
    assign reversed = (c1_reg < c0_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cap_read && slice_ok)
        begin
            cnt_reg <= ram_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata <= {7'd0, (is_read_reg ? 9'd0 : pts_reg), 32'(cnt_reg)};
            m_tuser <= (!is_read_reg && reversed) ? lda_pkg::STATUS_REVERSED
                                                  : lda_pkg::STATUS_OK;
        end
    end

    assign stat.is_read   = is_read_reg;
    assign stat.reversed  = reversed;
    assign stat.slice_ok  = slice_ok;
    assign stat.line_done = (x_reg == xe_reg) && (y_reg == ye_reg);
    assign stat.clr_last  = &clr_reg;

endmodule

// ===== rtl/line_density_accumulator.sv =====
// Top level of the line density accumulator.
// After reset the count store is cleared, one entry a cycle, all 2**AW entries (AW:
// address width, 524288 with the defaults); no item is taken meanwhile. A read item
// runs MUL, RDA, RDD, DONE; a draw runs MUL, SETUP, then LRD and LWR per cell drawn
// (read-modify-write of the single-port count memory), then DONE; a rejected draw runs
// MUL, DONE. Items are handled one at a time; a result waits in the output register.
// Reset is asynchronous, active low; it also restores both dimension registers to 256.
`timescale 1ns / 1ps
module line_density_accumulator #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int NUM_SLICES = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [lda_pkg::CFG_BITS-1:0] cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // col_start[15:0] col_end[31:16] level_start[49:32] level_end[67:50]
    // slice[70:68] read_row[78:71]
    input  logic [79:0]                  s_tdata,
    input  logic                         s_tuser,   // cmd[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,   // cell_count[31:0] points_drawn[40:32]
    output logic                         m_tuser    // status[0]
);

    lda_pkg::lda_cmd_t  cmd;
    lda_pkg::lda_stat_t stat;

    lda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lda_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .NUM_SLICES (NUM_SLICES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== rtl/lda_checker.sv =====
// Port-level checker of the line density accumulator, with its bind.
`timescale 1ns / 1ps
`include "line_density_accumulator_defines.svh"
module lda_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result stays offered
    `LDA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    // one item at a time: no accept in the cycle after an accept
    `LDA_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item accepted while busy")
    // a draw flagged reversed reports no cells and no count
    `LDA_ASSERT_NOW(a_reject_zero, m_tvalid && m_tuser, m_tdata[40:0] == 41'd0,
                    "rejected draw carries data")

endmodule

bind line_density_accumulator lda_checker u_lda_checker (.*);
